// ===== rtl/core/tprr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-level priority round-robin unit: shared types and helpers
// Request and response payloads, request and status codes, queue geometry
// and the circular pointer arithmetic used by the scheduler.
// ----------------------------------------------------------------------------
package tprr_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int NUM_LEVELS  = 3;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_W = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH);

   // Priority levels as seen on the request
   localparam logic [2:0] PRIO_LOW  = 3'd1;
   localparam logic [2:0] PRIO_MID  = 3'd3;
   localparam logic [2:0] PRIO_HIGH = 3'd5;

   // Internal level indexes
   localparam logic [1:0] LV_LOW  = 2'd0;
   localparam logic [1:0] LV_MID  = 2'd1;
   localparam logic [1:0] LV_HIGH = 2'd2;

   typedef enum logic [1:0] {
      REQ_ENQUEUE  = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_SELECT   = 2'd2,
      REQ_RESERVED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      req_code_type       req_type;
      logic [ID_BITS-1:0] task_id;
      logic [2:0]         task_level;
      logic               task_ready;
      logic               skip_state_check;
   } tprr_req_type;

   typedef struct packed {
      status_type         status;
      logic [ID_BITS-1:0] chosen_id;
      logic               chosen_valid;
      logic [TOTAL_W-1:0] total_tasks;
   } tprr_rsp_type;

   // Advance a circular pointer by one
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

   // Head plus count, wrapped; the sum stays below twice the depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] cnt);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(cnt);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return PTR_W'(sum);
   endfunction

   // Each level owns one contiguous slice of the shared store
   function automatic logic [ADDR_W-1:0] ram_addr(input logic [1:0]       lv,
                                                 input logic [PTR_W-1:0] ptr);
      return ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

// ===== rtl/core/tprr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tprr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/three_level_priority_round_robin_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-level priority round-robin unit
// Keeps circular queues of task ids for the low, mid and high priority
// levels in one shared RAM and serves enqueue, remove and select requests.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                     Handshake
//   -------   -----------------------   ------------------------------------
//   request   start, busy, req_data     taken when start high and busy low
//   response  rsp_strobe, rsp_data      one-cycle strobe, cannot be stalled
//
// Enqueue and rejected requests answer in the cycle after acceptance,
// select after the head read and then the copy to the tail. Remove reads
// one entry a cycle through each level in turn, then rotates the k entries
// ahead of the match behind the tail, one a cycle, through the RAM port.
// busy is high only while a select or remove is in progress; no stalls.
// Reset clears heads, counts and control; queue contents need no clearing.
// ----------------------------------------------------------------------------
module three_level_priority_round_robin_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tprr_pkg::tprr_req_type req_data,
   output logic                  rsp_strobe,
   output tprr_pkg::tprr_rsp_type rsp_data
);
   import tprr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_MOVE   = 4'b0100,
      S_SELECT = 4'b1000
   } fsm_type;

   // Control state
   fsm_type            state_ff,      state_in;
   logic [PTR_W-1:0]   head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]   head_in  [NUM_LEVELS];
   logic [CNT_W-1:0]   count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]   count_in [NUM_LEVELS];
   logic [TOTAL_W-1:0] total_ff,      total_in;
   logic               pend_ff,       pend_in;
   logic               wr_pend_ff,    wr_pend_in;
   logic               cur_end_ff,    cur_end_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // Working registers
   logic [ID_BITS-1:0] id_ff,       id_in;
   logic [1:0]         cur_lv_ff,   cur_lv_in;
   logic [CNT_W-1:0]   cur_i_ff,    cur_i_in;
   logic [PTR_W-1:0]   cur_ptr_ff,  cur_ptr_in;
   logic [1:0]         pend_lv_ff,  pend_lv_in;
   logic [CNT_W-1:0]   pend_i_ff,   pend_i_in;
   logic [CNT_W-1:0]   k_ff,        k_in;
   logic [PTR_W-1:0]   wr_ptr_ff,   wr_ptr_in;
   tprr_rsp_type       rsp_ff,      rsp_in;

   // Shared queue store
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ID_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ID_BITS-1:0] ram_rd_data;

   // Request decode
   logic [1:0]         enq_lv;
   logic               enq_lv_ok;
   logic [1:0]         nxt_lv;

   tprr_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (NUM_LEVELS * QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   // Map the priority level onto a queue index
   always_comb begin
      enq_lv    = LV_LOW;
      enq_lv_ok = 1'b1;
      unique case (req_data.task_level)
         PRIO_LOW:  enq_lv = LV_LOW;
         PRIO_MID:  enq_lv = LV_MID;
         PRIO_HIGH: enq_lv = LV_HIGH;
         default:   enq_lv_ok = 1'b0;
      endcase
   end

   assign nxt_lv = cur_lv_ff + 2'd1;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      pend_in       = pend_ff;
      wr_pend_in    = wr_pend_ff;
      cur_end_in    = cur_end_ff;
      rsp_strobe_in = 1'b0;
      id_in         = id_ff;
      cur_lv_in     = cur_lv_ff;
      cur_i_in      = cur_i_ff;
      cur_ptr_in    = cur_ptr_ff;
      pend_lv_in    = pend_lv_ff;
      pend_i_in     = pend_i_ff;
      k_in          = k_ff;
      wr_ptr_in     = wr_ptr_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in               = req_data.task_id;
               rsp_in.chosen_id    = '0;
               rsp_in.chosen_valid = 1'b0;
               unique case (req_data.req_type)
                  REQ_ENQUEUE: begin
                     rsp_strobe_in = 1'b1;
                     if (!req_data.task_ready && !req_data.skip_state_check) begin
                        rsp_in.status = ST_INVALID;
                     end else if (!enq_lv_ok) begin
                        rsp_in.status = ST_INVALID;
                     end else if (count_ff[enq_lv] == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        // append at the tail of the level
                        ram_we           = 1'b1;
                        ram_waddr        = ram_addr(enq_lv,
                                              ptr_add(head_ff[enq_lv], count_ff[enq_lv]));
                        ram_wdata        = req_data.task_id;
                        count_in[enq_lv] = count_ff[enq_lv] + CNT_W'(1);
                        total_in         = total_ff + TOTAL_W'(1);
                        rsp_in.status    = ST_OK;
                     end
                  end
                  REQ_REMOVE: begin
                     if (req_data.task_ready && !req_data.skip_state_check) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_INVALID;
                     end else begin
                        // walk from the head of the low queue
                        state_in   = S_SEARCH;
                        cur_lv_in  = LV_LOW;
                        cur_i_in   = '0;
                        cur_ptr_in = head_ff[LV_LOW];
                        cur_end_in = 1'b0;
                        pend_in    = 1'b0;
                     end
                  end
                  REQ_SELECT: begin
                     priority if (count_ff[LV_HIGH] != '0) begin
                        cur_lv_in = LV_HIGH;
                        ram_raddr = ram_addr(LV_HIGH, head_ff[LV_HIGH]);
                        state_in  = S_SELECT;
                     end else if (count_ff[LV_MID] != '0) begin
                        cur_lv_in = LV_MID;
                        ram_raddr = ram_addr(LV_MID, head_ff[LV_MID]);
                        state_in  = S_SELECT;
                     end else if (count_ff[LV_LOW] != '0) begin
                        cur_lv_in = LV_LOW;
                        ram_raddr = ram_addr(LV_LOW, head_ff[LV_LOW]);
                        state_in  = S_SELECT;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
                  REQ_RESERVED: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = ST_INVALID;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            pend_in = 1'b0;
            priority if (pend_ff && (ram_rd_data == id_ff)) begin
               // first match: rotate the entries ahead of it behind the tail
               state_in   = S_MOVE;
               cur_lv_in  = pend_lv_ff;
               k_in       = pend_i_ff;
               cur_i_in   = '0;
               cur_ptr_in = head_ff[pend_lv_ff];
               wr_ptr_in  = ptr_add(head_ff[pend_lv_ff], count_ff[pend_lv_ff]);
               wr_pend_in = 1'b0;
            end else if (cur_end_ff) begin
               // drain the last compare, then report a miss
               if (!pend_ff) begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = ST_NOT_FOUND;
               end
            end else if (cur_i_ff < count_ff[cur_lv_ff]) begin
               ram_raddr  = ram_addr(cur_lv_ff, cur_ptr_ff);
               pend_in    = 1'b1;
               pend_lv_in = cur_lv_ff;
               pend_i_in  = cur_i_ff;
               cur_i_in   = cur_i_ff + CNT_W'(1);
               cur_ptr_in = ptr_inc(cur_ptr_ff);
            end else begin
               // level exhausted: advance to the next one
               cur_i_in = '0;
               if (cur_lv_ff == LV_HIGH) begin
                  cur_end_in = 1'b1;
               end else begin
                  cur_lv_in  = nxt_lv;
                  cur_ptr_in = head_ff[nxt_lv];
               end
            end
         end

         S_MOVE: begin
            wr_pend_in = 1'b0;
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ram_addr(cur_lv_ff, wr_ptr_ff);
               ram_wdata = ram_rd_data;
               wr_ptr_in = ptr_inc(wr_ptr_ff);
            end
            if (cur_i_ff < k_ff) begin
               ram_raddr  = ram_addr(cur_lv_ff, cur_ptr_ff);
               wr_pend_in = 1'b1;
               cur_i_in   = cur_i_ff + CNT_W'(1);
               cur_ptr_in = ptr_inc(cur_ptr_ff);
            end else if (!wr_pend_ff) begin
               // new head sits just past the removed entry
               head_in[cur_lv_ff]  = ptr_inc(cur_ptr_ff);
               count_in[cur_lv_ff] = count_ff[cur_lv_ff] - CNT_W'(1);
               total_in            = total_ff - TOTAL_W'(1);
               state_in            = S_IDLE;
               rsp_strobe_in       = 1'b1;
               rsp_in.status       = ST_OK;
            end
         end

         S_SELECT: begin
            // copy head to tail and advance the head
            ram_we              = 1'b1;
            ram_waddr           = ram_addr(cur_lv_ff,
                                     ptr_add(head_ff[cur_lv_ff], count_ff[cur_lv_ff]));
            ram_wdata           = ram_rd_data;
            head_in[cur_lv_ff]  = ptr_inc(head_ff[cur_lv_ff]);
            state_in            = S_IDLE;
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = ST_OK;
            rsp_in.chosen_id    = ram_rd_data;
            rsp_in.chosen_valid = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.total_tasks = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         pend_ff       <= 1'b0;
         wr_pend_ff    <= 1'b0;
         cur_end_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         pend_ff       <= pend_in;
         wr_pend_ff    <= wr_pend_in;
         cur_end_ff    <= cur_end_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      cur_lv_ff  <= cur_lv_in;
      cur_i_ff   <= cur_i_in;
      cur_ptr_ff <= cur_ptr_in;
      pend_lv_ff <= pend_lv_in;
      pend_i_ff  <= pend_i_in;
      k_ff       <= k_in;
      wr_ptr_ff  <= wr_ptr_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
